FILE: rtl/core/speaker_segment_detector_unit_defines.svh
// Assertion macros shared by the speaker segment detector checkers.
// Included by the checker file; needs no other file.
`ifndef SPEAKER_SEGMENT_DETECTOR_UNIT_DEFINES_SVH
`define SPEAKER_SEGMENT_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while the reset signal is low.
`define SSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("speaker segment detector check failed");

// Next-cycle implication, disabled while the reset signal is low.
`define SSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("speaker segment detector check failed");

`endif

FILE: rtl/core/ssd_pkg.sv
// Shared types and constants of the speaker segment detector.
// Used by the lane, merge, top level and checker files; depends on nothing.
package ssd_pkg;

    localparam int NUM_LANES  = 4;
    localparam int NUM_SLOTS  = 2 * NUM_LANES;
    localparam int SCORE_W    = 16;
    localparam int TPF_W      = 7;
    localparam int OUT_TICK_W = 24;
    localparam int CFG_W      = 16;

    typedef logic [OUT_TICK_W-1:0] t_tick_out;

    typedef enum logic [1:0] {
        CFG_THRESHOLD       = 2'd0,
        CFG_TICKS_PER_FRAME = 2'd1,
        CFG_PAD_TICKS       = 2'd2,
        CFG_MIN_ON_TICKS    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SCORE_W-1:0] score_lane0;
        logic [SCORE_W-1:0] score_lane1;
        logic [SCORE_W-1:0] score_lane2;
        logic [SCORE_W-1:0] score_lane3;
        logic               end_of_session;
    } t_seg_req;

    typedef struct packed {
        logic [1:0] speaker;
        t_tick_out  start_tick;
        t_tick_out  end_tick;
        logic       last_of_run;
    } t_seg_res;

    typedef struct packed {
        logic [SCORE_W-1:0] threshold;
        logic [CFG_W-1:0]   pad_ticks;
        logic [CFG_W-1:0]   min_on_ticks;
    } t_seg_cfg;

    typedef struct packed {
        logic [1:0] speaker;
        t_tick_out  start_tick;
        t_tick_out  end_tick;
    } t_seg_slot;

    // Up to two finished segments per lane and request: a pushed-out pending
    // segment (first) and the flushed one at end of session (second).
    typedef struct packed {
        logic      first_vld;
        t_seg_slot first;
        logic      second_vld;
        t_seg_slot second;
    } t_lane_res;

endpackage

FILE: rtl/core/speaker_segment_detector_unit.sv
// Speaker segment detector: four speaker lanes turn per-frame activity
// scores into padded, merged speech segments. Depends on ssd_pkg, ssd_lane
// and ssd_merge.
//
// A request is taken while the merge stage is free, and all four lanes
// update their state in that cycle. Its finished segments (zero to eight)
// are held in the merge stage's slot buffer and, while i_stall is low,
// leave through the output register one per cycle; a request with none or
// one segment then leaves the input free every cycle. The next request is
// taken in the cycle in which the last segment of the previous one moves to
// the output register; o_stall is high only while the slot buffer still
// holds segments after that cycle. The last segment of each request carries
// last_of_run. There is no clearing pass after reset.
module speaker_segment_detector_unit #(
    parameter int TICK_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  ssd_pkg::t_seg_req             i_req,
    output logic                          o_stall,
    output logic                          o_valid,
    output ssd_pkg::t_seg_res             o_res,
    input  logic                          i_stall,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [ssd_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam logic [TICK_BITS-1:0] TickMax = '1;

    logic [ssd_pkg::SCORE_W-1:0] r_threshold;
    logic [ssd_pkg::TPF_W-1:0]   r_tpf;
    logic [ssd_pkg::CFG_W-1:0]   r_pad;
    logic [ssd_pkg::CFG_W-1:0]   r_min_on;
    logic [TICK_BITS-1:0]        r_frame_tick;

    logic [TICK_BITS-1:0]        n_frame_tick;
    logic [ssd_pkg::TPF_W-1:0]   tpf_eff;
    logic [TICK_BITS:0]          next_sum;
    logic [TICK_BITS:0]          last_sum;
    logic [TICK_BITS-1:0]        tick_last;
    logic                        accept;
    logic                        merge_free;
    ssd_pkg::t_seg_cfg           cfg;
    ssd_pkg::t_lane_res          lane_res [ssd_pkg::NUM_LANES];
    logic [ssd_pkg::SCORE_W-1:0] scores   [ssd_pkg::NUM_LANES];

    assign scores[0] = i_req.score_lane0;
    assign scores[1] = i_req.score_lane1;
    assign scores[2] = i_req.score_lane2;
    assign scores[3] = i_req.score_lane3;

    assign o_stall = !merge_free;
    assign accept  = i_valid && merge_free;

    assign cfg.threshold    = r_threshold;
    assign cfg.pad_ticks    = r_pad;
    assign cfg.min_on_ticks = r_min_on;

    // A frame length of zero counts as one tick.
    always_comb begin
        tpf_eff      = (r_tpf == '0) ? ssd_pkg::TPF_W'(1) : r_tpf;
        next_sum     = {1'b0, r_frame_tick} + (TICK_BITS+1)'(tpf_eff);
        last_sum     = {1'b0, r_frame_tick} + (TICK_BITS+1)'(tpf_eff - 1'b1);
        n_frame_tick = next_sum[TICK_BITS] ? TickMax : next_sum[TICK_BITS-1:0];
        tick_last    = last_sum[TICK_BITS] ? TickMax : last_sum[TICK_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ssd_pkg::SCORE_W'(32768);
            r_tpf       <= ssd_pkg::TPF_W'(8);
            r_pad       <= '0;
            r_min_on    <= '0;
        end else if (i_cfg_we) begin
            unique case (ssd_pkg::t_cfg_idx'(i_cfg_idx))
                ssd_pkg::CFG_THRESHOLD:       r_threshold <= i_cfg_data;
                ssd_pkg::CFG_TICKS_PER_FRAME: r_tpf       <= i_cfg_data[ssd_pkg::TPF_W-1:0];
                ssd_pkg::CFG_PAD_TICKS:       r_pad       <= i_cfg_data;
                ssd_pkg::CFG_MIN_ON_TICKS:    r_min_on    <= i_cfg_data;
                default:                      r_pad       <= r_pad;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_tick <= '0;
        end else if (accept) begin
            r_frame_tick <= i_req.end_of_session ? '0 : n_frame_tick;
        end
    end

    for (genvar g = 0; g < ssd_pkg::NUM_LANES; g++) begin : g_lane
        ssd_lane #(
            .TICK_BITS (TICK_BITS),
            .LANE      (g)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_accept    (accept),
            .i_score     (scores[g]),
            .i_last      (i_req.end_of_session),
            .i_cfg       (cfg),
            .i_tick      (r_frame_tick),
            .i_tick_last (tick_last),
            .o_res       (lane_res[g])
        );
    end

    ssd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_lane  (lane_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (o_res),
        .o_free  (merge_free)
    );

endmodule

FILE: rtl/core/ssd_lane.sv
// One speaker lane: threshold tracking, padding, pending-segment merge.
// Depends on ssd_pkg for the configuration and result structs.
module ssd_lane #(
    parameter int TICK_BITS = 24,
    parameter int LANE      = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [ssd_pkg::SCORE_W-1:0]    i_score,
    input  logic                           i_last,
    input  ssd_pkg::t_seg_cfg              i_cfg,
    input  logic [TICK_BITS-1:0]           i_tick,
    input  logic [TICK_BITS-1:0]           i_tick_last,
    output ssd_pkg::t_lane_res             o_res
);

    localparam logic [TICK_BITS-1:0] TickMax = '1;

    logic                 r_in_speech;
    logic [TICK_BITS-1:0] r_onset;
    logic                 r_pend_vld;
    logic [TICK_BITS-1:0] r_pend_start;
    logic [TICK_BITS-1:0] r_pend_end;

    logic                 n_in_speech;
    logic [TICK_BITS-1:0] n_onset;
    logic                 n_pend_vld;
    logic [TICK_BITS-1:0] n_pend_start;
    logic [TICK_BITS-1:0] n_pend_end;

    logic                 close_now;
    logic                 open_now;
    logic                 close_eos;
    logic                 close_any;
    logic [TICK_BITS-1:0] close_tick;
    logic [TICK_BITS-1:0] pad_ext;
    logic [TICK_BITS-1:0] min_ext;
    logic [TICK_BITS-1:0] cand_start;
    logic [TICK_BITS:0]   end_sum;
    logic [TICK_BITS-1:0] seg_end;
    logic                 seg_add;
    logic                 seg_merge;
    logic                 seg_push;
    logic                 old_long;
    logic                 new_long;

    assign pad_ext = TICK_BITS'(i_cfg.pad_ticks);
    assign min_ext = TICK_BITS'(i_cfg.min_on_ticks);

    always_comb begin
        close_now   = r_in_speech && (i_score < i_cfg.threshold);
        open_now    = !r_in_speech && (i_score > i_cfg.threshold);
        n_in_speech = close_now ? 1'b0 : (open_now ? 1'b1 : r_in_speech);
        n_onset     = open_now ? i_tick : r_onset;

        // Open speech at end of session closes at the last tick of the frame.
        close_eos  = i_last && n_in_speech;
        close_any  = close_now || close_eos;
        close_tick = close_now ? i_tick : i_tick_last;

        cand_start = (n_onset > pad_ext) ? (n_onset - pad_ext) : '0;
        end_sum    = {1'b0, close_tick} + {1'b0, pad_ext};
        seg_end    = end_sum[TICK_BITS] ? TickMax : end_sum[TICK_BITS-1:0];

        seg_add   = close_any && (seg_end > cand_start);
        seg_merge = seg_add && r_pend_vld && (r_pend_end >= cand_start);
        seg_push  = seg_add && !seg_merge;
        old_long  = (r_pend_end - r_pend_start) >= min_ext;

        n_pend_vld   = r_pend_vld || seg_add;
        n_pend_start = seg_push ? cand_start : r_pend_start;
        if (seg_merge) begin
            n_pend_end = (seg_end > r_pend_end) ? seg_end : r_pend_end;
        end else if (seg_push) begin
            n_pend_end = seg_end;
        end else begin
            n_pend_end = r_pend_end;
        end
        new_long = (n_pend_end - n_pend_start) >= min_ext;

        o_res.first_vld             = seg_push && r_pend_vld && old_long;
        o_res.first.speaker         = 2'(LANE);
        o_res.first.start_tick      = ssd_pkg::t_tick_out'(r_pend_start);
        o_res.first.end_tick        = ssd_pkg::t_tick_out'(r_pend_end);
        o_res.second_vld            = i_last && n_pend_vld && new_long;
        o_res.second.speaker        = 2'(LANE);
        o_res.second.start_tick     = ssd_pkg::t_tick_out'(n_pend_start);
        o_res.second.end_tick       = ssd_pkg::t_tick_out'(n_pend_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_speech  <= 1'b0;
            r_onset      <= '0;
            r_pend_vld   <= 1'b0;
            r_pend_start <= '0;
            r_pend_end   <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_in_speech  <= 1'b0;
                r_onset      <= '0;
                r_pend_vld   <= 1'b0;
                r_pend_start <= '0;
                r_pend_end   <= '0;
            end else begin
                r_in_speech  <= n_in_speech;
                r_onset      <= n_onset;
                r_pend_vld   <= n_pend_vld;
                r_pend_start <= n_pend_start;
                r_pend_end   <= n_pend_end;
            end
        end
    end

endmodule

FILE: rtl/core/ssd_merge.sv
// Merge stage: gathers the lane results of one request into slots and
// sends them out one per cycle while i_stall is low, in lane order. Depends on ssd_pkg.
module ssd_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ssd_pkg::t_lane_res  i_lane [ssd_pkg::NUM_LANES],
    input  logic                i_stall,
    output logic                o_valid,
    output ssd_pkg::t_seg_res   o_res,
    output logic                o_free
);

    localparam int SlotIw = $clog2(ssd_pkg::NUM_SLOTS);

    logic [ssd_pkg::NUM_SLOTS-1:0] r_slot_vld;
    ssd_pkg::t_seg_slot            r_slot [ssd_pkg::NUM_SLOTS];
    logic                          r_out_vld;
    ssd_pkg::t_seg_res             r_out;

    logic [ssd_pkg::NUM_SLOTS-1:0] n_slot_vld;
    logic [ssd_pkg::NUM_SLOTS-1:0] new_vld;
    logic [ssd_pkg::NUM_SLOTS-1:0] pop_mask;
    logic [ssd_pkg::NUM_SLOTS-1:0] remain;
    logic [SlotIw-1:0]             pick;
    logic                          out_free;
    logic                          pop;

    always_comb begin
        for (int i = 0; i < ssd_pkg::NUM_LANES; i++) begin
            new_vld[2*i]   = i_lane[i].first_vld;
            new_vld[2*i+1] = i_lane[i].second_vld;
        end
    end

    // Lowest occupied slot goes first, which keeps lane and time order.
    always_comb begin
        pick     = '0;
        pop_mask = '0;
        for (int k = ssd_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_slot_vld[k]) begin
                pick     = SlotIw'(k);
                pop_mask = '0;
                pop_mask[k] = 1'b1;
            end
        end
        out_free   = !r_out_vld || !i_stall;
        pop        = out_free && (r_slot_vld != '0);
        remain     = r_slot_vld & ~(pop ? pop_mask : '0);
        o_free     = (remain == '0);
        n_slot_vld = remain | (i_load ? new_vld : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_slot_vld <= n_slot_vld;
            if (pop) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < ssd_pkg::NUM_LANES; i++) begin
                r_slot[2*i]   <= i_lane[i].first;
                r_slot[2*i+1] <= i_lane[i].second;
            end
        end
        if (pop) begin
            r_out.speaker     <= r_slot[pick].speaker;
            r_out.start_tick  <= r_slot[pick].start_tick;
            r_out.end_tick    <= r_slot[pick].end_tick;
            r_out.last_of_run <= (remain == '0);
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule

FILE: rtl/core/ssd_checker.sv
// Port-level checks of the speaker segment detector, bound to the top level.
// Depends on ssd_pkg and the assertion macros in the defines header.
`include "speaker_segment_detector_unit_defines.svh"

module ssd_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_stall,
    input  logic              o_valid,
    input  logic              i_stall,
    input  ssd_pkg::t_seg_res o_res
);

    // A held result keeps its value.
    `SSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_res))

    // Reset leaves the output empty and the input open.
    `SSD_ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, !o_valid && !o_stall)

    // While a non-final segment waits at the output, the rest of its request
    // is still buffered, so no new request may enter.
    `SSD_ASSERT_NOW(a_run_blocks, i_clk, i_rst_n, o_valid && i_stall && !o_res.last_of_run, o_stall)

    // Segments of one request follow back to back in lane order.
    `SSD_ASSERT_NEXT(a_lane_order, i_clk, i_rst_n, o_valid && !i_stall && !o_res.last_of_run, o_valid && (o_res.speaker >= $past(o_res.speaker)))

endmodule

bind speaker_segment_detector_unit ssd_checker u_ssd_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for speaker_segment_detector_unit: a cycle-free predictor of
// the four speaker lanes checks every segment the block emits. Depends on ssd_pkg and
// the RTL of the block only.
module tb_top;

    localparam int TICK_BITS = 24;
    localparam logic [31:0] TICK_LIMIT = (32'd1 << TICK_BITS) - 32'd1;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PAD_FRAMES = 6;
    localparam int PHASE_ITEMS = 8;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_valid    = 1'b0;
    ssd_pkg::t_seg_req           i_req      = '0;
    logic                        o_stall;
    logic                        o_valid;
    ssd_pkg::t_seg_res           o_res;
    logic                        i_stall    = 1'b0;
    logic                        i_cfg_we   = 1'b0;
    logic [1:0]                  i_cfg_idx  = '0;
    logic [ssd_pkg::CFG_W-1:0]   i_cfg_data = '0;

    // Register copies and lane state of the predictor.
    logic [ssd_pkg::SCORE_W-1:0] thr_q    = 16'd32768;
    logic [ssd_pkg::TPF_W-1:0]   tpf_q    = 7'd8;
    logic [ssd_pkg::CFG_W-1:0]   pad_q    = '0;
    logic [ssd_pkg::CFG_W-1:0]   min_on_q = '0;
    logic [31:0]                 frame_tick_q = '0;
    logic                        speaking   [ssd_pkg::NUM_LANES];
    logic [31:0]                 onset_q    [ssd_pkg::NUM_LANES];
    logic                        held_vld   [ssd_pkg::NUM_LANES];
    logic [31:0]                 held_start [ssd_pkg::NUM_LANES];
    logic [31:0]                 held_end   [ssd_pkg::NUM_LANES];

    ssd_pkg::t_seg_res           frame_segs[$];
    ssd_pkg::t_seg_res           segments_due[$];

    int                          errors = 0;
    int                          quiet_cycles = 0;
    int                          hold_requests = 0;
    int                          holds_done = 0;
    int                          hold_left = 0;
    int                          mode_left = 0;
    t_stall_mode                 stall_mode = STALL_NONE;
    bit                          sender_gaps = 1'b1;
    int                          burst_left = 0;
    bit                          want_on [ssd_pkg::NUM_LANES];

    speaker_segment_detector_unit #(
        .TICK_BITS (TICK_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req      (i_req),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------ predictor

    function automatic logic [31:0] sat_tick(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = a + b;
        return (s > TICK_LIMIT) ? TICK_LIMIT : s[31:0];
    endfunction

    task automatic clear_lanes();
        frame_tick_q = '0;
        for (int lane = 0; lane < ssd_pkg::NUM_LANES; lane++) begin
            speaking[lane]   = 1'b0;
            onset_q[lane]    = '0;
            held_vld[lane]   = 1'b0;
            held_start[lane] = '0;
            held_end[lane]   = '0;
        end
    endtask

    task automatic keep_if_long(input int lane);
        ssd_pkg::t_seg_res r;
        if (held_end[lane] - held_start[lane] >= 32'(min_on_q)) begin
            r.speaker     = 2'(lane);
            r.start_tick  = held_start[lane][ssd_pkg::OUT_TICK_W-1:0];
            r.end_tick    = held_end[lane][ssd_pkg::OUT_TICK_W-1:0];
            r.last_of_run = 1'b0;
            frame_segs    = {frame_segs, r};
        end
    endtask

    // A new segment that overlaps or touches the held one extends it; otherwise the
    // held one is pushed out and the new one takes its place.
    task automatic add_segment(input int lane, input logic [31:0] s, input logic [31:0] e);
        if (e > s) begin
            if (held_vld[lane] && held_end[lane] >= s) begin
                if (e > held_end[lane])
                    held_end[lane] = e;
            end else begin
                if (held_vld[lane])
                    keep_if_long(lane);
                held_vld[lane]   = 1'b1;
                held_start[lane] = s;
                held_end[lane]   = e;
            end
        end
    endtask

    task automatic close_speech(input int lane, input logic [31:0] t);
        logic [31:0] s;
        s = (onset_q[lane] > 32'(pad_q)) ? onset_q[lane] - 32'(pad_q) : 32'd0;
        speaking[lane] = 1'b0;
        add_segment(lane, s, sat_tick(t, 32'(pad_q)));
    endtask

    task automatic detect_segments(input ssd_pkg::t_seg_req req);
        logic [ssd_pkg::SCORE_W-1:0] sc [ssd_pkg::NUM_LANES];
        logic [31:0]                 tpf;
        logic [31:0]                 t;
        ssd_pkg::t_seg_res           r;
        sc[0] = req.score_lane0;
        sc[1] = req.score_lane1;
        sc[2] = req.score_lane2;
        sc[3] = req.score_lane3;
        tpf = (tpf_q == '0) ? 32'd1 : 32'(tpf_q);
        t = frame_tick_q;
        frame_segs.delete();
        for (int lane = 0; lane < ssd_pkg::NUM_LANES; lane++) begin
            if (speaking[lane]) begin
                if (sc[lane] < thr_q)
                    close_speech(lane, t);
            end else if (sc[lane] > thr_q) begin
                speaking[lane] = 1'b1;
                onset_q[lane]  = t;
            end
            if (req.end_of_session) begin
                if (speaking[lane])
                    close_speech(lane, sat_tick(t, tpf - 32'd1));
                if (held_vld[lane])
                    keep_if_long(lane);
            end
        end
        if (req.end_of_session)
            clear_lanes();
        else
            frame_tick_q = sat_tick(t, tpf);
        if (frame_segs.size() > 0) begin
            r = frame_segs[frame_segs.size()-1];
            r.last_of_run = 1'b1;
            frame_segs[frame_segs.size()-1] = r;
        end
        foreach (frame_segs[k])
            segments_due = {segments_due, frame_segs[k]};
    endtask

    // ------------------------------------------------------------------ driving

    function automatic ssd_pkg::t_seg_req make_req(input logic [15:0] a,
                                                   input logic [15:0] b,
                                                   input logic [15:0] c,
                                                   input logic [15:0] d,
                                                   input logic eos);
        ssd_pkg::t_seg_req r;
        r.score_lane0    = a;
        r.score_lane1    = b;
        r.score_lane2    = c;
        r.score_lane3    = d;
        r.end_of_session = eos;
        return r;
    endfunction

    // Sender bursts: after each accepted request either continue or drop valid for a gap.
    task automatic pace();
        int gap;
        if (sender_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 8);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic send_frame(input ssd_pkg::t_seg_req req);
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        detect_segments(req);
        pace();
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers, one per cycle; the block must be idle.
    task automatic program_config(input logic [15:0] thr,
                                  input logic [ssd_pkg::TPF_W-1:0] tpf,
                                  input logic [15:0] pad, input logic [15:0] min_on);
        logic [ssd_pkg::CFG_W-1:0] data;
        ssd_pkg::t_cfg_idx         idx;
        for (int k = 0; k < 4; k++) begin
            idx = ssd_pkg::t_cfg_idx'(k);
            case (idx)
                ssd_pkg::CFG_THRESHOLD:       data = thr;
                ssd_pkg::CFG_TICKS_PER_FRAME: data = {9'($urandom_range(0, 511)), tpf};
                ssd_pkg::CFG_PAD_TICKS:       data = pad;
                ssd_pkg::CFG_MIN_ON_TICKS:    data = min_on;
                default:                      data = '0;
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= data;
            @(posedge i_clk);
            case (idx)
                ssd_pkg::CFG_THRESHOLD:       thr_q    = data;
                ssd_pkg::CFG_TICKS_PER_FRAME: tpf_q    = data[ssd_pkg::TPF_W-1:0];
                ssd_pkg::CFG_PAD_TICKS:       pad_q    = data;
                ssd_pkg::CFG_MIN_ON_TICKS:    min_on_q = data;
                default:                      ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] lane_score(input bit on);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return thr_q;
        if (on)
            return (thr_q == 16'hFFFF) ? thr_q : 16'($urandom_range(32'(thr_q) + 1, 65535));
        return (thr_q == 16'h0000) ? 16'h0000 : 16'($urandom_range(0, 32'(thr_q) - 1));
    endfunction

    // One session: lanes switch between speech and silence, last frame ends it.
    task automatic random_session(output int sent);
        int       len;
        logic [15:0] sc [ssd_pkg::NUM_LANES];
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            for (int lane = 0; lane < ssd_pkg::NUM_LANES; lane++) begin
                if ($urandom_range(0, 2) == 0)
                    want_on[lane] = ~want_on[lane];
                sc[lane] = lane_score(want_on[lane]);
            end
            send_frame(make_req(sc[0], sc[1], sc[2], sc[3], i == len - 1));
        end
        sent = len;
    endtask

    // ------------------------------------------------------------------ tests

    task automatic test_directed_defaults();
        send_frame(make_req(16'd32769, 16'd32768, 16'd0, 16'hFFFF, 1'b0));
        send_frame(make_req(16'd32768, 16'd40000, 16'd0, 16'hFFFF, 1'b0));
        send_frame(make_req(16'd0, 16'd32767, 16'hFFFF, 16'hFFFF, 1'b0));
        send_frame(make_req(16'd40000, 16'd0, 16'd0, 16'd100, 1'b0));
        send_frame(make_req(16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_frame(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        wait_drained();
    endtask

    task automatic test_register_extremes();
        // Zero threshold, zero ticks per frame, largest padding: starts clamp at zero.
        program_config(16'd0, 7'd0, 16'hFFFF, 16'd0);
        send_frame(make_req(16'd1, 16'd0, 16'd0, 16'd5, 1'b0));
        send_frame(make_req(16'd0, 16'd1, 16'd0, 16'd0, 1'b0));
        send_frame(make_req(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
        wait_drained();
        // Largest threshold: no score can rise above it.
        program_config(16'hFFFF, 7'd1, 16'd0, 16'd0);
        send_frame(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        wait_drained();
        // Speech that opens and closes in one single-tick frame is empty and dropped.
        program_config(16'd100, 7'd1, 16'd0, 16'd0);
        send_frame(make_req(16'd200, 16'd0, 16'd0, 16'd0, 1'b1));
        wait_drained();
        // Longest minimum duration drops every segment.
        program_config(16'd1000, 7'd127, 16'd3, 16'hFFFF);
        send_frame(make_req(16'd2000, 16'd2000, 16'd2000, 16'd2000, 1'b0));
        send_frame(make_req(16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_frame(make_req(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
        wait_drained();
        // Padding of half a frame makes consecutive segments touch and merge.
        program_config(16'd32768, 7'd8, 16'd4, 16'd0);
        send_frame(make_req(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b0));
        send_frame(make_req(16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_frame(make_req(16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b0));
        send_frame(make_req(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
        wait_drained();
    endtask

    task automatic test_max_results();
        // Every lane pushes out a held segment and flushes a new one: eight results.
        program_config(16'd32768, 7'd127, 16'd0, 16'd0);
        send_frame(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_frame(make_req(16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_frame(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_frame(make_req(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
        wait_drained();
    endtask

    task automatic test_long_padding();
        logic [15:0] b;
        logic [15:0] c;
        program_config(16'd32768, 7'd127, 16'hFFFF, 16'd0);
        sender_gaps = 1'b0;
        // Lane 0 speaks the whole session; lane 1 closes in the middle of it;
        // lane 2 is still open when the session ends. Every start clamps at zero.
        for (int n = 0; n < PAD_FRAMES; n++) begin
            b = (n >= 2 && n < 4) ? 16'hFFFF : 16'd0;
            c = (n >= 4) ? 16'hFFFF : 16'd0;
            send_frame(make_req(16'hFFFF, b, c, 16'd0, n == PAD_FRAMES - 1));
        end
        wait_drained();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_sessions();
        logic [15:0]               thr;
        logic [ssd_pkg::TPF_W-1:0] tpf;
        logic [15:0]               pad;
        logic [15:0]               min_on;
        int                        sent;
        int                        n;
        for (int phase = 0; phase < 6; phase++) begin
            thr = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(8000, 57000));
            case ($urandom_range(0, 9))
                0:       tpf = 7'd0;
                1:       tpf = 7'd127;
                2:       tpf = 7'd64;
                default: tpf = 7'($urandom_range(1, 64));
            endcase
            pad    = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
            min_on = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
            program_config(thr, tpf, pad, min_on);
            sender_gaps = (phase != 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_frame(make_req(16'($urandom), 16'($urandom), 16'($urandom),
                                        16'($urandom), 1'($urandom)));
                    sent++;
                end else begin
                    random_session(n);
                    sent += n;
                end
            end
            wait_drained();
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        // The receiver holds off while each end-of-session request brings four
        // segments, so the slot buffer fills and the block stalls its input.
        program_config(16'd32768, 7'd4, 16'd2, 16'd0);
        sender_gaps = 1'b0;
        hold_requests++;
        for (int i = 0; i < 8; i++) begin
            send_frame(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
            send_frame(make_req(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
        end
        wait_drained();
        sender_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------ receiver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 80);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:   i_stall <= 1'b0;
                STALL_LIGHT:  i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  i_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: i_stall <= ~i_stall;
                default:      i_stall <= 1'b0;
            endcase
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        ssd_pkg::t_seg_res want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (segments_due.size() == 0) begin
                $error("unexpected segment: speaker %0d, start %0d, end %0d",
                       o_res.speaker, o_res.start_tick, o_res.end_tick);
                errors++;
            end else begin
                want = segments_due.pop_front();
                check_field("speaker", 32'(want.speaker), 32'(o_res.speaker));
                check_field("start_tick", 32'(want.start_tick), 32'(o_res.start_tick));
                check_field("end_tick", 32'(want.end_tick), 32'(o_res.end_tick));
                check_field("last_of_run", 32'(want.last_of_run), 32'(o_res.last_of_run));
            end
        end
    end

    // Ends the run when nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        for (int lane = 0; lane < ssd_pkg::NUM_LANES; lane++)
            want_on[lane] = 1'b0;
        clear_lanes();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_register_extremes();
        test_max_results();
        test_long_padding();
        test_random_sessions();
        test_backpressure();
        wait_drained();
        if (errors == 0 && segments_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
